/* sv/cuid_pkg.sv */
package cuid_pkg;

  // base36 digit cell
  localparam int unsigned DIG_W     = 6;
  localparam int unsigned DIG_IDX_W = 3;     // selects a digit of the widest field (8 digits)
  localparam int unsigned RADIX     = 36;
  localparam int unsigned CARRY_LIM = RADIX / 2;

  // field widths and digit counts
  localparam int unsigned TS_W        = 42;
  localparam int unsigned TS_DIGITS   = 8;
  localparam int unsigned PID_W       = 23;
  localparam int unsigned PID_DIGITS  = 5;
  localparam int unsigned HOST_W      = 13;
  localparam int unsigned HOST_DIGITS = 3;
  localparam int unsigned RAND_W      = 32;
  localparam int unsigned RAND_DIGITS = 4;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned IN_DATA_W   = 136;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam int unsigned COUNTER_DIGITS_DEF = 4;

  // random scaling: floor(r * 36^4 / (2^32 - 1)), saturated
  localparam int unsigned RAND_K   = 1679616;
  localparam int unsigned RAND_S_W = $clog2(RAND_K);

  // configuration
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = HOST_W;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_SUM    = 1'b1;
  localparam logic [HOST_W-1:0]    HOST_RESET      = 13'd36;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_C     = 7'h63;
  localparam logic [CHAR_W-1:0] CHAR_0     = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 7'h7a;
  localparam logic [CHAR_W-1:0] CHAR_A_OFS = 7'h57;  // 'a' - 10

  function automatic longint unsigned pow36(input int unsigned k);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < k; i++) begin
      p = p * RADIX;
    end
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] b36_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIG_W'(10)) begin
      c = CHAR_0 + CHAR_W'(d);
    end else begin
      c = CHAR_A_OFS + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

/* sv/cuid_b36_conv.sv */
// Bit-serial binary to base36: one input bit per cycle, MSB first, into a row
// of digit cells (double and add). Carry out of a cell is digit >= 18, so the
// cells do not ripple. Digits beyond NDIG are dropped (value mod 36^NDIG).
module cuid_b36_conv #(
  parameter int unsigned W    = 8,
  parameter int unsigned NDIG = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [W-1:0]                           value_i,
  output logic                                   busy_o,
  output logic [NDIG-1:0][cuid_pkg::DIG_W-1:0]   digits_o
);
  import cuid_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0]              cnt_q, cnt_d;
  logic [W-1:0]               sh_q, sh_d;
  logic [NDIG-1:0][DIG_W-1:0] dig_q, dig_d;
  logic [NDIG-1:0]            carry, cin;
  logic [DIG_W:0]             dbl;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      carry[k] = (dig_q[k] >= DIG_W'(CARRY_LIM));
    end
    cin[0] = sh_q[W-1];
    for (int k = 1; k < NDIG; k++) begin
      cin[k] = carry[k-1];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    sh_d  = sh_q;
    dig_d = dig_q;
    dbl   = '0;
    if (start_i) begin
      cnt_d = CW'(W);
      sh_d  = value_i;
      dig_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      sh_d  = {sh_q[W-2:0], 1'b0};
      for (int k = 0; k < NDIG; k++) begin
        dbl = {dig_q[k], 1'b0} + (DIG_W+1)'(cin[k]);
        if (carry[k]) begin
          dbl = dbl - (DIG_W+1)'(RADIX);
        end
        dig_d[k] = dbl[DIG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    dig_q <= dig_d;
  end

  assign busy_o   = (cnt_q != '0);
  assign digits_o = dig_q;

endmodule

/* sv/cuid_rand_scale.sv */
// Shift-add multiply by 36^4 (one bit of r per cycle), then one correction
// step for the division by 2^32-1: s = q + (q + lo >= 2^32-1), saturated.
module cuid_rand_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cuid_pkg::RAND_W-1:0]   rand_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [cuid_pkg::RAND_S_W-1:0] scaled_o
);
  import cuid_pkg::*;

  localparam int unsigned AW = RAND_W + RAND_S_W;
  localparam int unsigned CW = $clog2(RAND_W + 2);
  localparam logic [RAND_S_W-1:0] K_S   = RAND_S_W'(RAND_K);
  localparam logic [RAND_S_W-1:0] K_MAX = RAND_S_W'(RAND_K - 1);

  logic [CW-1:0]       cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [RAND_W-1:0]   r_q, r_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic [RAND_S_W-1:0] s_q, s_d;
  logic [RAND_W:0]     wsum;
  logic [RAND_S_W-1:0] sq;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    r_d    = r_q;
    acc_d  = acc_q;
    s_d    = s_q;
    wsum   = {1'b0, acc_q[RAND_W-1:0]} + (RAND_W+1)'(acc_q[AW-1:RAND_W]);
    sq     = acc_q[AW-1:RAND_W] + RAND_S_W'(wsum >= (RAND_W+1)'({RAND_W{1'b1}}));
    if (start_i) begin
      cnt_d = CW'(RAND_W + 1);
      r_d   = rand_i;
      acc_d = '0;
    end else if (cnt_q > CW'(1)) begin
      cnt_d = cnt_q - 1'b1;
      r_d   = {r_q[RAND_W-2:0], 1'b0};
      acc_d = {acc_q[AW-2:0], 1'b0} + (r_q[RAND_W-1] ? AW'(K_S) : '0);
    end else if (cnt_q == CW'(1)) begin
      cnt_d  = '0;
      done_d = 1'b1;
      s_d    = (sq >= K_S) ? K_MAX : sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    acc_q <= acc_d;
    s_q   <= s_d;
  end

  assign busy_o   = (cnt_q != '0) || done_q;
  assign done_o   = done_q;
  assign scaled_o = s_q;

endmodule

/* sv/cuid_generator.sv */
// From the accepting edge to tvalid of the first character: serial scaling of the
//   random words, a handoff to the converters, the bit-serial base36 conversion,
//   the exit from the wait state and the output register.
// A new item is taken only after the last character of the previous one has
//   been registered for output.
// Reset: sequence counter 0, format_mode 0 (cuid), host_sum 36, no item held.
module cuid_generator
  import cuid_pkg::*;
#(
  parameter int unsigned COUNTER_DIGITS = COUNTER_DIGITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: timestamp_ms[41:0], process_id[64:42], rand_a[96:65], rand_b[128:97]
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [IN_DATA_W-1:0]       s_axis_tdata,
  // tdata: char_out[6:0]; tlast: last_char
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  // Counter wraps at 36^COUNTER_DIGITS; the stored value may equal the wrap.
  localparam longint unsigned WRAP_L = pow36(COUNTER_DIGITS);
  localparam int unsigned     CNT_W  = $clog2(WRAP_L + 1);
  localparam logic [CNT_W-1:0] CNT_WRAP = CNT_W'(WRAP_L);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_WAIT, ST_EMIT} state_e;
  typedef enum logic [3:0] {
    SEG_C, SEG_TS, SEG_CNT, SEG_PID0, SEG_PID1, SEG_HOST0, SEG_HOST1, SEG_RA, SEG_RB
  } seg_e;

  state_e               state_q;
  seg_e                 seg_q;
  logic [DIG_IDX_W-1:0] dig_q;
  logic [CNT_W-1:0]     seq_q;
  logic                 fmt_q;
  logic [HOST_W-1:0]    host_q;
  logic                 out_vld_q;
  logic [CHAR_W-1:0]    out_char_q;
  logic                 out_last_q;

  logic                 in_acc;
  logic [CNT_W-1:0]     cnt_use;

  // ---------------------------------------------------------------------------
  // Digit engines. Every field is converted in parallel; the random words go
  // through the serial scaler first.
  // ---------------------------------------------------------------------------
  logic [TS_DIGITS-1:0][DIG_W-1:0]      ts_digs;
  logic [PID_DIGITS-1:0][DIG_W-1:0]     pid_digs;
  logic [HOST_DIGITS-1:0][DIG_W-1:0]    host_digs;
  logic [COUNTER_DIGITS-1:0][DIG_W-1:0] cnt_digs;
  logic [RAND_DIGITS-1:0][DIG_W-1:0]    ra_digs, rb_digs;
  logic ts_busy, pid_busy, host_busy, cnt_busy, ra_busy, rb_busy;
  logic sa_busy, sb_busy, sa_done, sb_done;
  logic [RAND_S_W-1:0] sa_val, sb_val;
  logic all_idle;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cnt_use = (seq_q >= CNT_WRAP) ? '0 : seq_q;

  cuid_b36_conv #(.W(TS_W), .NDIG(TS_DIGITS)) u_ts_conv (
    .clk_i, .rst_ni, .start_i(in_acc), .value_i(s_axis_tdata[41:0]),
    .busy_o(ts_busy), .digits_o(ts_digs)
  );

  cuid_b36_conv #(.W(PID_W), .NDIG(PID_DIGITS)) u_pid_conv (
    .clk_i, .rst_ni, .start_i(in_acc), .value_i(s_axis_tdata[64:42]),
    .busy_o(pid_busy), .digits_o(pid_digs)
  );

  cuid_b36_conv #(.W(HOST_W), .NDIG(HOST_DIGITS)) u_host_conv (
    .clk_i, .rst_ni, .start_i(in_acc), .value_i(host_q),
    .busy_o(host_busy), .digits_o(host_digs)
  );

  cuid_b36_conv #(.W(CNT_W), .NDIG(COUNTER_DIGITS)) u_cnt_conv (
    .clk_i, .rst_ni, .start_i(in_acc), .value_i(cnt_use),
    .busy_o(cnt_busy), .digits_o(cnt_digs)
  );

  cuid_rand_scale u_ra_scale (
    .clk_i, .rst_ni, .start_i(in_acc), .rand_i(s_axis_tdata[96:65]),
    .busy_o(sa_busy), .done_o(sa_done), .scaled_o(sa_val)
  );

  cuid_rand_scale u_rb_scale (
    .clk_i, .rst_ni, .start_i(in_acc), .rand_i(s_axis_tdata[128:97]),
    .busy_o(sb_busy), .done_o(sb_done), .scaled_o(sb_val)
  );

  cuid_b36_conv #(.W(RAND_S_W), .NDIG(RAND_DIGITS)) u_ra_conv (
    .clk_i, .rst_ni, .start_i(sa_done), .value_i(sa_val),
    .busy_o(ra_busy), .digits_o(ra_digs)
  );

  cuid_b36_conv #(.W(RAND_S_W), .NDIG(RAND_DIGITS)) u_rb_conv (
    .clk_i, .rst_ni, .start_i(sb_done), .value_i(sb_val),
    .busy_o(rb_busy), .digits_o(rb_digs)
  );

  assign all_idle = !(ts_busy | pid_busy | host_busy | cnt_busy |
                      sa_busy | sb_busy | ra_busy | rb_busy);

  // ---------------------------------------------------------------------------
  // Digit selection. Leading digits come from the highest nonzero cell; a
  // value with a single digit gives '0' as its second leading digit.
  // ---------------------------------------------------------------------------
  logic [DIG_IDX_W-1:0] pid_top, host_top, cnt_top;
  logic [DIG_W-1:0]     ts_sel, cnt_sel, ra_sel, rb_sel;
  logic [DIG_W-1:0]     pid_l0, pid_l1, host_l0, host_l1;
  logic [CHAR_W-1:0]    pid_c1, host_c1;

  always_comb begin
    pid_top  = '0;
    host_top = '0;
    cnt_top  = '0;
    for (int k = 0; k < PID_DIGITS; k++) begin
      if (pid_digs[k] != '0) pid_top = DIG_IDX_W'(k);
    end
    for (int k = 0; k < HOST_DIGITS; k++) begin
      if (host_digs[k] != '0) host_top = DIG_IDX_W'(k);
    end
    for (int k = 0; k < COUNTER_DIGITS; k++) begin
      if (cnt_digs[k] != '0) cnt_top = DIG_IDX_W'(k);
    end
  end

  always_comb begin
    ts_sel  = '0;
    cnt_sel = '0;
    ra_sel  = '0;
    rb_sel  = '0;
    pid_l0  = '0;
    pid_l1  = '0;
    host_l0 = '0;
    host_l1 = '0;
    for (int k = 0; k < TS_DIGITS; k++) begin
      if (dig_q == DIG_IDX_W'(k)) ts_sel = ts_digs[k];
    end
    for (int k = 0; k < COUNTER_DIGITS; k++) begin
      if (dig_q == DIG_IDX_W'(k)) cnt_sel = cnt_digs[k];
    end
    for (int k = 0; k < RAND_DIGITS; k++) begin
      if (dig_q == DIG_IDX_W'(k)) begin
        ra_sel = ra_digs[k];
        rb_sel = rb_digs[k];
      end
    end
    for (int k = 0; k < PID_DIGITS; k++) begin
      if (pid_top == DIG_IDX_W'(k))     pid_l0 = pid_digs[k];
      if (pid_top == DIG_IDX_W'(k + 1)) pid_l1 = pid_digs[k];
    end
    for (int k = 0; k < HOST_DIGITS; k++) begin
      if (host_top == DIG_IDX_W'(k))     host_l0 = host_digs[k];
      if (host_top == DIG_IDX_W'(k + 1)) host_l1 = host_digs[k];
    end
  end

  assign pid_c1  = (pid_top == '0)  ? CHAR_0 : b36_char(pid_l1);
  assign host_c1 = (host_top == '0) ? CHAR_0 : b36_char(host_l1);

  // ---------------------------------------------------------------------------
  // Character sequencer: segment plus digit index, one character per cycle
  // while the output register is free.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0]    ch;
  logic                 ch_last;
  seg_e                 seg_nx;
  logic [DIG_IDX_W-1:0] dig_nx;
  logic                 out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    ch      = CHAR_C;
    ch_last = 1'b0;
    seg_nx  = seg_q;
    dig_nx  = dig_q - 1'b1;
    unique case (seg_q)
      SEG_C: begin
        ch     = CHAR_C;
        seg_nx = SEG_TS;
        dig_nx = DIG_IDX_W'(TS_DIGITS - 1);
      end
      SEG_TS: begin
        ch = b36_char(ts_sel);
        if (dig_q == '0) begin
          seg_nx = SEG_CNT;
          dig_nx = fmt_q ? cnt_top : DIG_IDX_W'(COUNTER_DIGITS - 1);
        end
      end
      SEG_CNT: begin
        ch = b36_char(cnt_sel);
        if (dig_q == '0) seg_nx = SEG_PID0;
      end
      SEG_PID0: begin
        ch     = b36_char(pid_l0);
        seg_nx = fmt_q ? SEG_HOST0 : SEG_PID1;
      end
      SEG_PID1: begin
        ch     = pid_c1;
        seg_nx = SEG_HOST0;
      end
      SEG_HOST0: begin
        ch = b36_char(host_l0);
        if (fmt_q) begin
          seg_nx = SEG_RA;
          dig_nx = DIG_IDX_W'(1);           // slug keeps the two low digits
        end else begin
          seg_nx = SEG_HOST1;
        end
      end
      SEG_HOST1: begin
        ch     = host_c1;
        seg_nx = SEG_RA;
        dig_nx = DIG_IDX_W'(RAND_DIGITS - 1);
      end
      SEG_RA: begin
        ch = b36_char(ra_sel);
        if (dig_q == '0) begin
          ch_last = fmt_q;
          seg_nx  = SEG_RB;
          dig_nx  = DIG_IDX_W'(RAND_DIGITS - 1);
        end
      end
      SEG_RB: begin
        ch = b36_char(rb_sel);
        if (dig_q == '0) ch_last = 1'b1;
      end
      default: begin
        ch      = CHAR_C;
        ch_last = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control, counter and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      seg_q      <= SEG_C;
      dig_q      <= '0;
      seq_q      <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_char_q <= '0;
    end else begin
      // while emitting, a taken character is always replaced by the next one
      if (m_axis_tready && (state_q != ST_EMIT)) out_vld_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            seq_q   <= cnt_use + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (all_idle) begin
            state_q <= ST_EMIT;
            seg_q   <= fmt_q ? SEG_TS : SEG_C;
            dig_q   <= DIG_IDX_W'(1);       // slug sends the two low timestamp digits, from digit 1
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_char_q <= ch;
            out_last_q <= ch_last;
            seg_q      <= seg_nx;
            dig_q      <= dig_nx;
            if (ch_last) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= 1'b0;
      host_q <= HOST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORMAT_MODE: fmt_q  <= cfg_data_i[0];
        REG_HOST_SUM:    host_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q <= CNT_WRAP)
    else $error("sequence counter past wrap");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second item taken while one is in flight");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0) &&
      ((m_axis_tdata[6:0] >= CHAR_0 && m_axis_tdata[6:0] <= CHAR_9) ||
       (m_axis_tdata[6:0] >= CHAR_LO_A && m_axis_tdata[6:0] <= CHAR_LO_Z)))
    else $error("character outside base36 set");

  a_emit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> all_idle)
    else $error("characters sent while a digit engine runs");

endmodule

/* tb/tb.sv */
module tb;
  import cuid_pkg::*;

  // format_mode values
  localparam logic MODE_CUID = 1'b0;
  localparam logic MODE_SLUG = 1'b1;

  // wrap point of the sequence counter at four counter digits
  localparam longint unsigned SEQ_WRAP = 64'd1679616;
  // largest timestamp that still fits eight base36 digits
  localparam logic [TS_W-1:0] TS_MAX8 = 42'd2821109907455;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 120;

  // Expected characters of the identifiers in flight, with their own copy of
  // the registers and of the sequence counter.
  class id_predictor;
    typedef struct packed {
      logic              last;
      logic [CHAR_W-1:0] ch;
    } id_char_t;

    id_char_t        expected_chars[$];
    logic            fmt_mode;
    logic [HOST_W-1:0] host_val;
    logic [20:0]     seq_cnt;
    int              errors;
    int              n_checked;

    function new();
      fmt_mode  = MODE_CUID;
      host_val  = HOST_RESET;
      seq_cnt   = '0;
      errors    = 0;
      n_checked = 0;
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 30) $display("ERROR char %0d: %s", n_checked, msg);
    endtask

    function int pending();
      return expected_chars.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FORMAT_MODE) fmt_mode = val[0];
      else if (idx == REG_HOST_SUM) host_val = val[HOST_W-1:0];
    endfunction

    function logic [CHAR_W-1:0] digit_char(input longint unsigned d);
      string alphabet;
      alphabet = "0123456789abcdefghijklmnopqrstuvwxyz";
      return CHAR_W'(alphabet[int'(d)]);
    endfunction

    function void push(input logic [CHAR_W-1:0] ch);
      id_char_t e;
      e.last = 1'b0;
      e.ch   = ch;
      expected_chars.push_back(e);
    endfunction

    // v as exactly n digits, most significant first
    function void push_padded(input longint unsigned v, input int n);
      longint unsigned dg[16];
      for (int i = n - 1; i >= 0; i--) begin
        dg[i] = v % RADIX;
        v = v / RADIX;
      end
      for (int i = 0; i < n; i++) push(digit_char(dg[i]));
    endfunction

    function int num_digits(input longint unsigned v);
      int n;
      n = 1;
      while (v >= RADIX) begin
        v = v / RADIX;
        n++;
      end
      return n;
    endfunction

    // leading digit pos of the unpadded form; '0' when the value is shorter
    function logic [CHAR_W-1:0] lead_digit(input longint unsigned v, input int pos);
      int n;
      n = num_digits(v);
      if (pos >= n) return CHAR_0;
      for (int i = 0; i < n - 1 - pos; i++) v = v / RADIX;
      return digit_char(v % RADIX);
    endfunction

    function longint unsigned scale_rand(input logic [RAND_W-1:0] r);
      longint unsigned s;
      s = (longint'(r) * RAND_K) / 64'hFFFF_FFFF;
      if (s > RAND_K - 1) s = RAND_K - 1;
      return s;
    endfunction

    function void note_request(input logic [TS_W-1:0] ts, input logic [PID_W-1:0] pid,
                               input logic [RAND_W-1:0] ra, input logic [RAND_W-1:0] rb);
      longint unsigned cnt;
      longint unsigned tsv;
      cnt = seq_cnt;
      tsv = ts;
      if (cnt >= SEQ_WRAP) cnt = 0;
      seq_cnt = 21'(cnt + 1);
      if (fmt_mode == MODE_CUID) begin
        push(CHAR_C);
        push_padded(tsv, TS_DIGITS);
        push_padded(cnt, COUNTER_DIGITS_DEF);
        push(lead_digit(pid, 0));
        push(lead_digit(pid, 1));
        push(lead_digit(host_val, 0));
        push(lead_digit(host_val, 1));
        push_padded(scale_rand(ra), RAND_DIGITS);
        push_padded(scale_rand(rb), RAND_DIGITS);
      end else begin
        push_padded(tsv, 2);
        push_padded(cnt, num_digits(cnt));
        push(lead_digit(pid, 0));
        push(lead_digit(host_val, 0));
        push_padded(scale_rand(ra), 2);
      end
      expected_chars[$].last = 1'b1;
    endfunction

    task check_char(input logic [CHAR_W-1:0] ch, input logic last);
      id_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h last %b", ch, last));
      end else begin
        e = expected_chars.pop_front();
        if (ch !== e.ch) report($sformatf("char %h, want %h", ch, e.ch));
        if (last !== e.last) report($sformatf("last %b, want %b", last, e.last));
      end
      n_checked++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cuid_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  id_predictor ids = new();

  int idle_pct;    // sender gap chance per cycle, percent
  int stall_pct;   // receiver stall chance per cycle, percent
  int cycles = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("cuid_generator: mismatch");
      $finish;
    end
  end

  // receiver: check each accepted char, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        ids.check_char(m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one request; returns at the edge that accepted it
  task send_item(input logic [TS_W-1:0] ts, input logic [PID_W-1:0] pid,
                 input logic [RAND_W-1:0] ra, input logic [RAND_W-1:0] rb);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, rb, ra, pid, ts};
    do @(posedge clk_i); while (!s_axis_tready);
    ids.note_request(ts, pid, ra, rb);
  endtask

  // sender holds off until every expected char is back
  task drain();
    s_axis_tvalid <= 1'b0;
    while (ids.pending() != 0) @(posedge clk_i);
  endtask

  // only called with the block idle
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    ids.write_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // random request with a bias toward edges of each field
  task rand_item();
    logic [TS_W-1:0]   ts;
    logic [PID_W-1:0]  pid;
    logic [RAND_W-1:0] ra;
    logic [RAND_W-1:0] rb;
    case ($urandom_range(3))
      0: ts = {10'($urandom_range(1023)), $urandom};
      1: ts = TS_W'($urandom_range(1295));
      2: ts = {10'($urandom_range(1023)), $urandom} % (TS_MAX8 + 1);
      default: begin
        case ($urandom_range(3))
          0: ts = '0;
          1: ts = '1;
          2: ts = TS_MAX8;
          default: ts = TS_MAX8 + 1;
        endcase
      end
    endcase
    case ($urandom_range(3))
      0: pid = PID_W'($urandom);
      1: pid = PID_W'($urandom_range(35));
      2: pid = PID_W'($urandom_range(36, 1295));
      default: pid = $urandom_range(1) ? 23'd4194304 : '1;
    endcase
    ra = ($urandom_range(3) != 0) ? $urandom : ($urandom_range(1) ? '1 : '0);
    rb = ($urandom_range(3) != 0) ? $urandom : ($urandom_range(1) ? '1 : '0);
    send_item(ts, pid, ra, rb);
  endtask

  initial begin
    logic mode;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_FORMAT_MODE;
    cfg_data_i    <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config is cuid mode, two-digit host
    send_item('0, '0, '0, '0);
    send_item('1, '1, '1, '1);                        // oversized ts, saturated randoms
    send_item(TS_MAX8, 23'd4194304, 32'h8000_0000, 32'h0000_0001);
    send_item(42'd35, 23'd35, 32'h0000_0001, 32'hFFFF_FFFE); // short ts, one-digit pid
    send_item(42'd36, 23'd36, 32'h7FFF_FFFF, 32'h1234_5678);
    drain();
    write_reg(REG_HOST_SUM, 13'd5);                   // one-digit host
    send_item(42'd1000000000000, 23'd1295, '0, '1);
    send_item(TS_MAX8 + 1, 23'd46656, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    write_reg(REG_HOST_SUM, 13'h1FFF);
    write_reg(REG_FORMAT_MODE, 13'h1FFF);             // upper bits dropped -> slug
    send_item('0, '0, '0, '0);
    send_item('1, '1, '1, '1);
    send_item(42'd35, 23'd5, '1, '0);
    send_item(42'd1296, 23'd46655, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    write_reg(REG_HOST_SUM, 13'd0);
    send_item(42'd12345678, 23'd4194304, 32'h0000_FFFF, 32'hFFFF_0000);
    send_item(TS_MAX8, 23'd1, 32'h0123_4567, 32'h89AB_CDEF);
    drain();
    write_reg(REG_FORMAT_MODE, 13'h1FFE);             // upper bits dropped -> cuid
    send_item('1, '0, '0, '0);
    send_item(42'd1679616, 23'd8191, 32'hDEAD_BEEF, 32'h0000_0000);

    // random phases: none, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      mode = p[0] ? MODE_SLUG : MODE_CUID;
      write_reg(REG_FORMAT_MODE, {12'(p * 13), mode});
      case (p)
        0: write_reg(REG_HOST_SUM, CFG_DATA_W'($urandom_range(36, 5156)));
        1: write_reg(REG_HOST_SUM, 13'd5156);
        2: write_reg(REG_HOST_SUM, 13'd36);
        default: write_reg(REG_HOST_SUM, $urandom_range(1) ?
                           CFG_DATA_W'($urandom_range(35)) : CFG_DATA_W'($urandom));
      endcase
      for (int k = 0; k < 40; k++) begin
        // halfway: let everything come back, then flip the format
        if (k == 20) begin
          drain();
          mode = ~mode;
          write_reg(REG_FORMAT_MODE, {12'd0, mode});
        end
        rand_item();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ids.pending() != 0) ids.report($sformatf("%0d chars never came", ids.pending()));
    if (ids.errors == 0) begin
      $display("cuid_generator: match");
    end else begin
      $display("cuid_generator: mismatch");
    end
    $finish;
  end

endmodule
